// ===== rtl/sc2a_pkg.sv =====
// types, scan code constants and character roms for the scan code translator
package sc2a_pkg;

	localparam int ROM_DEPTH = 58;

	localparam logic [7:0] PREFIX_CODE = 8'hE0;
	localparam logic [6:0] LSHIFT_CODE = 7'h2A;
	localparam logic [6:0] RSHIFT_CODE = 7'h36;
	localparam logic [6:0] CTRL_CODE   = 7'h1D;
	localparam logic [6:0] ALT_CODE    = 7'h38;
	localparam logic [6:0] CAPS_CODE   = 7'h3A;
	localparam logic [6:0] DEL_CODE    = 7'h53;
	localparam logic [6:0] F1_CODE     = 7'h3B;
	localparam logic [6:0] F2_CODE     = 7'h3C;
	localparam logic [6:0] UP_CODE     = 7'h48;
	localparam logic [6:0] ESC_CODE    = 7'h01;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_F1   = 3'd1,
		EV_F2   = 3'd2,
		EV_CAD  = 3'd3,
		EV_UP   = 3'd4
	} event_t;

	// keyboard modifier and prefix state
	typedef struct packed {
		logic shift;
		logic control;
		logic alt;
		logic caps;
		logic prefix;
	} kbd_flags_t;

	// one translated beat
	typedef struct packed {
		logic       char_valid;
		logic [6:0] char_code;
		event_t     event_code;
	} xlate_res_t;

	localparam logic [6:0] ROM_PLAIN [ROM_DEPTH] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20
	};

	localparam logic [6:0] ROM_SHIFTED [ROM_DEPTH] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20
	};

	// rom lookup, entries past the rom read as zero
	function automatic logic [6:0] rom_lookup(input logic [6:0] code, input logic shifted);
		logic [6:0] ch;
		ch = 7'h00;
		if (code < 7'(ROM_DEPTH)) begin
			ch = shifted ? ROM_SHIFTED[code[5:0]] : ROM_PLAIN[code[5:0]];
		end
		return ch;
	endfunction

endpackage

// ===== rtl/scancode_to_ascii_translator.sv =====
// top level: set-1 scan code to ascii translator with stream ports
//
// channel  dir  tdata                                   tuser
// s_axis   in   [7:0] scan_code                         -
// m_axis   out  [6:0] char_code, [9:7] event_code       [0] char_valid
//
// every input beat yields exactly one output beat, passing through the input register,
// then translate, then the result register
// one beat is accepted per cycle while s_axis_tready is high; the modifier flags update as a beat
// leaves the input register, so the next beat in the input register always sees them
// arst_n clears the flags and both valid bits; payload registers are not reset
// an output stall backs up into the input register and then drops s_axis_tready
module scancode_to_ascii_translator #(
	parameter int TABLE_ENTRIES = 58
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] scan_code
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [6:0] char_code, [9:7] event_code, [15:10] zero
	output logic        m_axis_tuser    // [0] char_valid
);
	import sc2a_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] scan_s1;

	// result register
	logic       valid_s2;
	xlate_res_t res_s2;

	// keyboard state
	kbd_flags_t flags_q;
	kbd_flags_t flags_next;
	xlate_res_t res_comb;

	logic in_beat;
	logic adv_s1;
	logic out_free;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	sc2a_xlate #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_xlate (
		.scan_code (scan_s1),
		.flags     (flags_q),
		.flags_next(flags_next),
		.res       (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (s_axis_tready) valid_s1 <= s_axis_tvalid;
			if (out_free)      valid_s2 <= valid_s1;
			// flags commit only when the beat moves on
			if (adv_s1)        flags_q  <= flags_next;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) scan_s1 <= s_axis_tdata;
		if (adv_s1)  res_s2  <= res_comb;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.char_valid;
	assign m_axis_tdata  = {6'b0, res_s2.event_code, res_s2.char_code};

	// a character and an event never come together
	a_char_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.char_valid |-> res_s2.event_code == EV_NONE)
		else $error("character beat carries an event");

	// char_valid tracks a nonzero character
	a_valid_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.char_valid == (res_s2.char_code != 7'h00))
		else $error("char_valid does not match char_code");

	// a prefix beat leaves the prefix flag set
	a_prefix_set: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && scan_s1 == PREFIX_CODE |=> flags_q.prefix)
		else $error("prefix flag not set after prefix byte");

	// ctrl-alt-del only reported while both modifiers are held
	a_cad_mods: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res_comb.event_code == EV_CAD |-> flags_q.control && flags_q.alt)
		else $error("ctrl-alt-del without modifiers");

	// an empty result register never blocks the input side
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("input stalled with empty result register");

endmodule

// ===== rtl/sc2a_xlate.sv =====
// combinational scan code decode: flag update and character translation
module sc2a_xlate #(
	parameter int TABLE_ENTRIES = 58
) (
	input  logic [7:0]          scan_code,
	input  sc2a_pkg::kbd_flags_t flags,
	output sc2a_pkg::kbd_flags_t flags_next,
	output sc2a_pkg::xlate_res_t res
);
	import sc2a_pkg::*;

	logic [6:0] code;
	logic       release_key;
	logic       is_shift;
	logic [6:0] ch;
	logic [6:0] rom_ch;

	assign code        = scan_code[6:0];
	assign release_key = scan_code[7];
	assign is_shift    = (code == LSHIFT_CODE) || (code == RSHIFT_CODE);
	assign rom_ch      = rom_lookup(code, flags.shift);

	always_comb begin
		flags_next     = flags;
		res.char_valid = 1'b0;
		res.char_code  = 7'h00;
		res.event_code = EV_NONE;
		ch             = rom_ch;

		if (scan_code == PREFIX_CODE) begin
			flags_next.prefix = 1'b1;
		end else if (flags.prefix) begin
			flags_next.prefix = 1'b0;
			if (code == CTRL_CODE) flags_next.control = !release_key;
			if (code == ALT_CODE)  flags_next.alt     = !release_key;
			if (!release_key && code == UP_CODE) res.event_code = EV_UP;
		end else if (release_key) begin
			if (is_shift)          flags_next.shift   = 1'b0;
			if (code == CTRL_CODE) flags_next.control = 1'b0;
			if (code == ALT_CODE)  flags_next.alt     = 1'b0;
		end else if (code == ESC_CODE) begin
			// escape gives nothing
		end else if (is_shift) begin
			flags_next.shift = 1'b1;
		end else if (code == ALT_CODE) begin
			flags_next.alt = 1'b1;
		end else if (code == CTRL_CODE) begin
			flags_next.control = 1'b1;
		end else if (code == CAPS_CODE) begin
			flags_next.caps = !flags.caps;
		end else if (flags.control && flags.alt && code == DEL_CODE) begin
			res.event_code = EV_CAD;
		end else if (code == F1_CODE) begin
			res.event_code = EV_F1;
		end else if (code == F2_CODE) begin
			res.event_code = EV_F2;
		end else if ({1'b0, code} < 8'(TABLE_ENTRIES)) begin
			// caps swaps letter case by flipping bit 5
			if (flags.caps && ((ch >= 7'h41 && ch <= 7'h5A) || (ch >= 7'h61 && ch <= 7'h7A))) begin
				ch = ch ^ 7'h20;
			end
			if (flags.control && (ch == 7'h63 || ch == 7'h43)) ch = 7'h0A;
			if (flags.control && (ch == 7'h64 || ch == 7'h44)) ch = 7'h04;
			res.char_code  = ch;
			res.char_valid = (ch != 7'h00);
		end
	end

endmodule

// ===== test/tb_scancode_to_ascii_translator.sv =====
// testbench for the scan code translator: directed rows then random key sequences, predictor-checked
`timescale 1ns / 1ps

module tb_scancode_to_ascii_translator;
	import sc2a_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_BEATS = 1300;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int KEYMAP_SIZE  = 58;

	localparam logic [6:0] KEY_C = 7'h2E;
	localparam logic [6:0] KEY_D = 7'h20;

	typedef struct packed {
		logic       valid;
		logic [6:0] ch;
		event_t     ev;
	} key_result_t;

	// one stimulus row; pinned rows carry a hand-written result
	typedef struct packed {
		logic [7:0]  scan;
		logic        pinned;
		key_result_t res;
	} scan_row_t;

	localparam key_result_t NO_KEY = {1'b0, 7'h00, EV_NONE};

	// set-1 layout, unshifted and shifted
	localparam logic [6:0] PLAIN_KEYS [KEYMAP_SIZE] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20
	};

	localparam logic [6:0] SHIFTED_KEYS [KEYMAP_SIZE] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20
	};

	// opening rows: extremes, special keys, prefix handling
	localparam scan_row_t OPENING_ROWS [27] = '{
		{8'h00, 1'b1, NO_KEY},                       // code zero, empty entry
		{8'h7F, 1'b1, NO_KEY},                       // highest press, past the map
		{8'hFF, 1'b1, NO_KEY},                       // all ones, a release
		{8'h80, 1'b1, NO_KEY},                       // release of code zero
		{8'h1E, 1'b1, {1'b1, 7'h61, EV_NONE}},       // plain 'a'
		{1'b0, ESC_CODE, 1'b1, NO_KEY},
		{1'b0, F1_CODE, 1'b1, {1'b0, 7'h00, EV_F1}},
		{1'b0, F2_CODE, 1'b1, {1'b0, 7'h00, EV_F2}},
		{1'b0, LSHIFT_CODE, 1'b1, NO_KEY},
		{8'h1E, 1'b0, NO_KEY},                       // shifted letter
		{1'b0, CAPS_CODE, 1'b1, NO_KEY},
		{8'h1E, 1'b0, NO_KEY},                       // shift and caps cancel
		{8'h02, 1'b0, NO_KEY},                       // shifted digit, caps has no effect
		{1'b1, LSHIFT_CODE, 1'b1, NO_KEY},
		{1'b0, CTRL_CODE, 1'b1, NO_KEY},
		{1'b0, KEY_C, 1'b0, NO_KEY},                 // ctrl-c
		{1'b0, KEY_D, 1'b0, NO_KEY},                 // ctrl-d
		{1'b0, ALT_CODE, 1'b1, NO_KEY},
		{1'b0, DEL_CODE, 1'b1, {1'b0, 7'h00, EV_CAD}},
		{PREFIX_CODE, 1'b1, NO_KEY},
		{PREFIX_CODE, 1'b1, NO_KEY},                 // second prefix stays one prefix
		{1'b0, UP_CODE, 1'b1, {1'b0, 7'h00, EV_UP}},
		{PREFIX_CODE, 1'b1, NO_KEY},
		{1'b1, CTRL_CODE, 1'b1, NO_KEY},             // right ctrl release
		{PREFIX_CODE, 1'b1, NO_KEY},
		{1'b1, ALT_CODE, 1'b1, NO_KEY},              // right alt release
		{1'b0, DEL_CODE, 1'b1, NO_KEY}               // no chord held any more
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;

	// predictor copy of the keyboard state
	logic shift_down = 1'b0;
	logic ctrl_down = 1'b0;
	logic alt_down = 1'b0;
	logic caps_lock = 1'b0;
	logic e0_seen = 1'b0;

	scan_row_t   sent_rows[$];
	key_result_t pending_keys[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int beats_sent = 0;
	int beats_out = 0;
	int chars_seen = 0;
	int events_seen = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	scancode_to_ascii_translator #(
		.TABLE_ENTRIES(58)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// expected beat for one scan code, advancing the keyboard state
	function automatic key_result_t translate_scan(input logic [7:0] scan);
		logic [6:0]  key;
		logic        is_break;
		logic [6:0]  ch;
		key_result_t r;
		key = scan[6:0];
		is_break = scan[7];
		r = NO_KEY;
		if (scan == PREFIX_CODE) begin
			e0_seen = 1'b1;
			return r;
		end
		if (e0_seen) begin
			e0_seen = 1'b0;
			if (is_break) begin
				if (key == CTRL_CODE) ctrl_down = 1'b0;
				if (key == ALT_CODE) alt_down = 1'b0;
			end else begin
				if (key == CTRL_CODE) ctrl_down = 1'b1;
				if (key == ALT_CODE) alt_down = 1'b1;
				if (key == UP_CODE) r.ev = EV_UP;
			end
			return r;
		end
		if (is_break) begin
			if (key == LSHIFT_CODE || key == RSHIFT_CODE) shift_down = 1'b0;
			if (key == CTRL_CODE) ctrl_down = 1'b0;
			if (key == ALT_CODE) alt_down = 1'b0;
			return r;
		end
		if (key == ESC_CODE) return r;
		if (key == LSHIFT_CODE || key == RSHIFT_CODE) begin
			shift_down = 1'b1;
			return r;
		end
		if (key == ALT_CODE) begin
			alt_down = 1'b1;
			return r;
		end
		if (key == CTRL_CODE) begin
			ctrl_down = 1'b1;
			return r;
		end
		if (key == CAPS_CODE) begin
			caps_lock = ~caps_lock;
			return r;
		end
		if (ctrl_down && alt_down && key == DEL_CODE) begin
			r.ev = EV_CAD;
			return r;
		end
		if (key == F1_CODE) begin
			r.ev = EV_F1;
			return r;
		end
		if (key == F2_CODE) begin
			r.ev = EV_F2;
			return r;
		end
		if (key >= 7'(KEYMAP_SIZE)) return r;
		ch = shift_down ? SHIFTED_KEYS[key[5:0]] : PLAIN_KEYS[key[5:0]];
		// caps lock swaps letter case only
		if (caps_lock) begin
			if (ch >= 7'h41 && ch <= 7'h5A) ch = ch + 7'd32;
			else if (ch >= 7'h61 && ch <= 7'h7A) ch = ch - 7'd32;
		end
		if (ctrl_down && (ch == 7'h63 || ch == 7'h43)) ch = 7'h0A;
		if (ctrl_down && (ch == 7'h64 || ch == 7'h44)) ch = 7'h04;
		r.valid = (ch != 7'h00);
		r.ch = ch;
		return r;
	endfunction

	task automatic flag_mismatch(input string field, input int want, input int got);
		$error("%s: expected %0h, actual %0h", field, want, got);
		mismatches++;
	endtask

	// receiver side: random stalls at the current rate
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// beat monitor: predicts on input beats, checks output beats, runs the watchdog
	always @(posedge clk) begin : watch_beats
		key_result_t want;
		scan_row_t   row;
		logic        moved;
		moved = 1'b0;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				beats_out++;
				if (pending_keys.size() == 0) begin
					$error("output beat with no scan code waiting: tdata %h tuser %b",
						m_axis_tdata, m_axis_tuser);
					mismatches++;
				end else begin
					want = pending_keys.pop_front();
					if (want.valid) chars_seen++;
					if (want.ev != EV_NONE) events_seen++;
					if (m_axis_tuser !== want.valid)
						flag_mismatch("char_valid", want.valid, m_axis_tuser);
					if (m_axis_tdata[6:0] !== want.ch)
						flag_mismatch("char_code", want.ch, m_axis_tdata[6:0]);
					if (m_axis_tdata[9:7] !== want.ev)
						flag_mismatch("event_code", want.ev, m_axis_tdata[9:7]);
					if (m_axis_tdata[15:10] !== 6'h00)
						flag_mismatch("tdata padding", 0, m_axis_tdata[15:10]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				moved = 1'b1;
				row = sent_rows.pop_front();
				want = translate_scan(s_axis_tdata);
				pending_keys.push_back(row.pinned ? row.res : want);
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("no beat moved for %0d cycles, %0d results outstanding",
				STALL_LIMIT, pending_keys.size());
			$display("tb_scancode_to_ascii_translator: FAIL");
			$finish;
		end
	end

	// holds the beat until it is taken; idles first at the current rate
	task automatic send_row(input scan_row_t row);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		sent_rows.push_back(row);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= row.scan;
		do @(posedge clk); while (!s_axis_tready);
		beats_sent++;
	endtask

	task automatic send_scan(input logic [7:0] scan);
		send_row({scan, 1'b0, NO_KEY});
	endtask

	// ctrl and alt come from either side, the right one behind a prefix
	task automatic send_modifier(input logic [6:0] key, input logic is_break);
		if ((key == CTRL_CODE || key == ALT_CODE) && $urandom_range(1)) send_scan(PREFIX_CODE);
		send_scan({is_break, key});
	endtask

	function automatic logic [6:0] any_mapped_key();
		return 7'($urandom_range(KEYMAP_SIZE - 1));
	endfunction

	// one short, mostly well-formed key sequence
	task automatic type_keys();
		int         pick;
		int         n;
		logic [6:0] key;
		logic [6:0] ext_keys [6];
		ext_keys = '{UP_CODE, CTRL_CODE, ALT_CODE, DEL_CODE, F1_CODE, 7'h00};
		pick = $urandom_range(99);
		n = $urandom_range(4, 1);
		if (pick < 38) begin
			// ordinary typing, now and then past the map
			key = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : any_mapped_key();
			send_scan({1'b0, key});
			if ($urandom_range(1)) send_scan({1'b1, key});
		end else if (pick < 50) begin
			key = $urandom_range(1) ? LSHIFT_CODE : RSHIFT_CODE;
			send_scan({1'b0, key});
			repeat (n) send_scan({1'b0, any_mapped_key()});
			send_scan({1'b1, key});
		end else if (pick < 56) begin
			send_scan({1'b0, CAPS_CODE});
			send_scan({1'b1, CAPS_CODE});
		end else if (pick < 66) begin
			// control chords, c and d favored
			send_modifier(CTRL_CODE, 1'b0);
			repeat (n) begin
				case ($urandom_range(2))
					0: key = KEY_C;
					1: key = KEY_D;
					default: key = any_mapped_key();
				endcase
				send_scan({1'b0, key});
			end
			send_modifier(CTRL_CODE, 1'b1);
		end else if (pick < 73) begin
			// three-key reset, modifiers in either order
			if ($urandom_range(1)) begin
				send_modifier(CTRL_CODE, 1'b0);
				send_modifier(ALT_CODE, 1'b0);
			end else begin
				send_modifier(ALT_CODE, 1'b0);
				send_modifier(CTRL_CODE, 1'b0);
			end
			send_scan({1'b0, DEL_CODE});
			send_scan({1'b1, DEL_CODE});
			send_modifier(ALT_CODE, 1'b1);
			send_modifier(CTRL_CODE, 1'b1);
		end else if (pick < 79) begin
			key = $urandom_range(1) ? F1_CODE : F2_CODE;
			send_scan({1'b0, key});
			send_scan({1'b1, key});
		end else if (pick < 87) begin
			// extended codes, sometimes a doubled prefix or a random byte after it
			send_scan(PREFIX_CODE);
			if ($urandom_range(3) == 0) send_scan(PREFIX_CODE);
			key = ext_keys[3'($urandom_range(5))];
			if (key == 7'h00) send_scan(8'($urandom_range(255)));
			else send_scan({1'($urandom_range(1)), key});
		end else if (pick < 93) begin
			send_scan({1'b1, 7'($urandom_range(127))});
		end else begin
			send_scan(8'($urandom_range(255)));
		end
	endtask

	initial begin
		int phase_end;
		int opening;
		// phase one: light sender gaps, heavy receiver stalls
		send_idle_pct = 16;
		stall_pct = 80;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (OPENING_ROWS[i]) send_row(OPENING_ROWS[i]);
		opening = beats_sent;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 16;
					stall_pct = 80;
				end
				1: begin
					send_idle_pct = 80;
					stall_pct = 16;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			phase_end = beats_sent + RANDOM_BEATS / 3;
			while (beats_sent < phase_end) type_keys();
		end
		s_axis_tvalid <= 1'b0;
		// let the monitor take the last input beat before draining
		@(posedge clk);
		while (pending_keys.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d scan code beats (%0d directed), checked %0d output beats",
			beats_sent, opening, beats_out);
		$display("of which %0d carried characters and %0d carried events, %0d mismatches",
			chars_seen, events_seen, mismatches);
		if (mismatches == 0) begin
			$display("tb_scancode_to_ascii_translator: PASS");
		end else begin
			$display("tb_scancode_to_ascii_translator: FAIL");
		end
		$finish;
	end

endmodule
